FILE: rtl/ambs_pkg.sv
`default_nettype none

package ambs_pkg;

  // Fixed field and register widths of the stream and configuration ports.
  localparam int PIX_FIELD_W = 16;
  localparam int SIZE_W      = 11;
  localparam int THRESH_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 2'd2;

  localparam logic [SIZE_W-1:0]   FRAME_WIDTH_RST    = 11'd640;
  localparam logic [SIZE_W-1:0]   FRAME_HEIGHT_RST   = 11'd480;
  localparam logic [THRESH_W-1:0] DIFF_THRESHOLD_RST = 16'd2500;

endpackage

`default_nettype wire

FILE: rtl/ambs_ram.sv
`default_nettype none

module ambs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/approx_median_background_subtract_core.sv
`default_nettype none

// Approximated median background subtraction on a raster pixel stream. The block takes one
// pixel per clock while the output is not stalled and gives one result per pixel, which
// passes the compare stage into the output register. The background memory (MAX_COLS x
// MAX_ROWS entries) is read in the cycle a pixel is accepted; the next stage compares the
// pixel with the stored background, steps the background one count toward the pixel and
// writes it back, with a bypass from the last write so back-to-back pixels at the same
// position see the updated value. That single read-modify-write per pixel sets the rate.
// The memory is not cleared: the first frame after reset loads every position and reports
// all pixels as background, so a later frame must not reach positions the first frame did
// not cover. A request with tuser set starts a new frame at position (0,0). The user must
// write configuration only while no pixel is in flight; the block does not enforce it.
module approx_median_background_subtract_core #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [15:0] pixel_value
  input  wire logic [ambs_pkg::PIX_FIELD_W-1:0]   s_axis_tdata,
  // [0] frame_start
  input  wire logic                               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [15:0] background_value
  output logic      [ambs_pkg::PIX_FIELD_W-1:0]   m_axis_tdata,
  // [0] foreground
  output logic                                    m_axis_tuser,
  output logic                                    m_axis_tlast,
  input  wire logic                               cfg_we,
  input  wire logic [ambs_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [ambs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DEPTH   = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PIX_W   = (PIXEL_BITS < ambs_pkg::PIX_FIELD_W) ? PIXEL_BITS
                                                                : ambs_pkg::PIX_FIELD_W;
  localparam int MAX_DIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int CMP_W   = ((MAX_DIM >= (2 ** ambs_pkg::SIZE_W)) ? $clog2(MAX_DIM + 1)
                                                                 : ambs_pkg::SIZE_W) + 1;

  // Configuration registers.
  logic [ambs_pkg::SIZE_W-1:0]   frame_width;
  logic [ambs_pkg::SIZE_W-1:0]   frame_height;
  logic [ambs_pkg::THRESH_W-1:0] diff_threshold;

  // Position counters and model state.
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic             model_loaded;

  // Compare stage.
  logic              s1_valid;
  logic [PIX_W-1:0]  s1_pixel;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_last;

  // Last write to the background memory, for the bypass.
  logic              lw_valid;
  logic [ADDR_W-1:0] lw_addr;
  logic [PIX_W-1:0]  lw_data;

  logic [CMP_W-1:0]  width_cmp;
  logic [CMP_W-1:0]  height_cmp;
  logic              in_accept;
  logic              s1_advance;
  logic [COL_W-1:0]  col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [COL_W-1:0]  column_count_next;
  logic [ROW_W-1:0]  row_count_next;
  logic              row_end;
  logic              frame_end;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  ram_rdata;
  logic [PIX_W-1:0]  stored;
  logic [PIX_W-1:0]  diff;
  logic [PIX_W-1:0]  bg_next;
  logic              fg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= ambs_pkg::FRAME_WIDTH_RST;
      frame_height   <= ambs_pkg::FRAME_HEIGHT_RST;
      diff_threshold <= ambs_pkg::DIFF_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ambs_pkg::REG_FRAME_WIDTH:    frame_width    <= cfg_wdata[ambs_pkg::SIZE_W-1:0];
        ambs_pkg::REG_FRAME_HEIGHT:   frame_height   <= cfg_wdata[ambs_pkg::SIZE_W-1:0];
        ambs_pkg::REG_DIFF_THRESHOLD: diff_threshold <= cfg_wdata[ambs_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // A size of zero counts as one; a size beyond the memory counts as the memory size.
  always_comb begin
    if (frame_width == '0) begin
      width_cmp = CMP_W'(1);
    end else if (CMP_W'(frame_width) > CMP_W'(MAX_COLS)) begin
      width_cmp = CMP_W'(MAX_COLS);
    end else begin
      width_cmp = CMP_W'(frame_width);
    end
    if (frame_height == '0) begin
      height_cmp = CMP_W'(1);
    end else if (CMP_W'(frame_height) > CMP_W'(MAX_ROWS)) begin
      height_cmp = CMP_W'(MAX_ROWS);
    end else begin
      height_cmp = CMP_W'(frame_height);
    end
  end

  assign s1_advance    = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_cur   = s_axis_tuser ? '0 : column_count;
    row_cur   = s_axis_tuser ? '0 : row_count;
    row_end   = (CMP_W'(col_cur) + CMP_W'(1)) >= width_cmp;
    frame_end = row_end && ((CMP_W'(row_cur) + CMP_W'(1)) >= height_cmp);
    if (row_end) begin
      column_count_next = '0;
      row_count_next    = frame_end ? '0 : ROW_W'(row_cur + 1'b1);
    end else begin
      column_count_next = COL_W'(col_cur + 1'b1);
      row_count_next    = row_cur;
    end
    rd_addr = ADDR_W'(ADDR_W'(row_cur) * ADDR_W'(MAX_COLS)) + ADDR_W'(col_cur);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pixel <= s_axis_tdata[PIX_W-1:0];
      s1_addr  <= rd_addr;
      s1_last  <= frame_end;
    end
  end

  ambs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_bg_ram (
    .clk     (clk),
    .wr_en   (s1_advance),
    .wr_addr (s1_addr),
    .wr_data (bg_next),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // The read of a pixel accepted in the same cycle as the previous write misses that
  // write, so the last written value wins whenever the position matches.
  always_comb begin
    stored  = (lw_valid && (lw_addr == s1_addr)) ? lw_data : ram_rdata;
    diff    = (s1_pixel > stored) ? (s1_pixel - stored) : (stored - s1_pixel);
    fg_next = 1'b0;
    bg_next = s1_pixel;
    if (model_loaded) begin
      fg_next = ambs_pkg::THRESH_W'(diff) > diff_threshold;
      if (s1_pixel > stored) begin
        bg_next = stored + 1'b1;
      end else if (s1_pixel < stored) begin
        bg_next = stored - 1'b1;
      end else begin
        bg_next = stored;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid     <= 1'b0;
      model_loaded <= 1'b0;
    end else if (s1_advance) begin
      lw_valid <= 1'b1;
      if (s1_last) begin
        model_loaded <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      lw_addr <= s1_addr;
      lw_data <= bg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_axis_tdata <= ambs_pkg::PIX_FIELD_W'(bg_next);
      m_axis_tuser <= fg_next;
      m_axis_tlast <= s1_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ambs_checker.sv
`default_nettype none

module ambs_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [ambs_pkg::PIX_FIELD_W-1:0] m_axis_tdata,
  input wire logic                             m_axis_tuser,
  input wire logic                             m_axis_tlast
);

  logic [2:0] pending;
  logic       seen_last;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Requests accepted but not yet delivered; the pipeline holds at most two.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      seen_last <= 1'b0;
    end else begin
      pending <= pending + 3'(in_acc) - 3'(out_acc);
      if (out_acc && m_axis_tlast) begin
        seen_last <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output request changed while stalled");

  a_depth: assert property (@(posedge clk) disable iff (rst) pending <= 3'd2)
    else $error("more than two requests in flight");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    pending == 3'd0 |-> !m_axis_tvalid)
    else $error("result shown with no request in flight");

  a_first_frame_bg: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !seen_last |-> !m_axis_tuser)
    else $error("foreground reported while the first frame loads the model");

endmodule

bind approx_median_background_subtract_core ambs_checker u_ambs_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: tb/approx_median_background_subtract_core_tb.sv
`default_nettype none

module approx_median_background_subtract_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COLS    = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 500;

  typedef struct packed {
    logic                             foreground;
    logic [ambs_pkg::PIX_FIELD_W-1:0] background;
    logic                             frame_last;
  } pixel_result_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [ambs_pkg::PIX_FIELD_W-1:0] s_axis_tdata = '0;
  logic                             s_axis_tuser = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [ambs_pkg::PIX_FIELD_W-1:0] m_axis_tdata;
  logic                             m_axis_tuser;
  logic                             m_axis_tlast;
  logic                             cfg_we = 1'b0;
  logic [ambs_pkg::CFG_IDX_W-1:0]   cfg_addr = ambs_pkg::REG_FRAME_WIDTH;
  logic [ambs_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Shadow of the block's state and registers.
  bit [ambs_pkg::PIX_FIELD_W-1:0] bg_mem [0:STORE_DEPTH-1];
  bit                             written [0:STORE_DEPTH-1];
  int                             col_pos = 0;
  int                             row_pos = 0;
  bit                             model_loaded = 1'b0;
  logic [ambs_pkg::SIZE_W-1:0]    cfg_width = ambs_pkg::FRAME_WIDTH_RST;
  logic [ambs_pkg::SIZE_W-1:0]    cfg_height = ambs_pkg::FRAME_HEIGHT_RST;
  logic [ambs_pkg::THRESH_W-1:0]  cfg_threshold = ambs_pkg::DIFF_THRESHOLD_RST;

  pixel_result_t pending_results[$];
  int            fail_count = 0;
  int            cycle_count = 0;
  bit            no_idle = 1'b0;
  bit            result_seen = 1'b0;
  int            sink_hold = 0;

  approx_median_background_subtract_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int clamp_size(int v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int next_address(logic start);
    return start ? 0 : row_pos * MAX_COLS + col_pos;
  endfunction

  // Once the model is loaded, a pixel must land on a position that the loading pass
  // wrote; a frame start brings the counters back to a known position.
  function automatic logic safe_start(logic start);
    if (model_loaded && !written[next_address(start)]) return 1'b1;
    return start;
  endfunction

  // A pixel d counts away from the stored background of the next position.
  function automatic logic [ambs_pkg::PIX_FIELD_W-1:0] near_pixel(logic start, int d);
    int bg;
    int t;
    bg = bg_mem[next_address(start)];
    t = bg + d;
    if (t < 0 || t > 65535) t = bg - d;
    if (t < 0) t = 0;
    else if (t > 65535) t = 65535;
    return ambs_pkg::PIX_FIELD_W'(t);
  endfunction

  function automatic pixel_result_t step_background(
    logic [ambs_pkg::PIX_FIELD_W-1:0] pix,
    logic start
  );
    pixel_result_t r;
    int w;
    int h;
    int addr;
    int diff;
    logic [ambs_pkg::PIX_FIELD_W-1:0] bg;
    logic row_end;
    w = clamp_size(int'(cfg_width), MAX_COLS);
    h = clamp_size(int'(cfg_height), MAX_ROWS);
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    addr = row_pos * MAX_COLS + col_pos;
    bg = bg_mem[addr];
    r.foreground = 1'b0;
    if (!model_loaded) begin
      bg = pix;
    end else begin
      diff = int'(pix) - int'(bg);
      if (diff < 0) diff = -diff;
      r.foreground = (diff > int'(cfg_threshold));
      if (pix > bg) bg = bg + 1'b1;
      else if (pix < bg) bg = bg - 1'b1;
    end
    bg_mem[addr] = bg;
    written[addr] = 1'b1;
    row_end = (col_pos + 1 >= w);
    r.frame_last = row_end && (row_pos + 1 >= h);
    r.background = bg;
    if (row_end) begin
      col_pos = 0;
      row_pos = r.frame_last ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    if (r.frame_last) model_loaded = 1'b1;
    return r;
  endfunction

  task automatic send_pixel(logic [ambs_pkg::PIX_FIELD_W-1:0] pix, logic start);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(step_background(pix, start));
  endtask

  // The sender holds off until every pending result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(
    logic [ambs_pkg::CFG_IDX_W-1:0]  idx,
    logic [ambs_pkg::CFG_DATA_W-1:0] value
  );
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      ambs_pkg::REG_FRAME_WIDTH:    cfg_width = value[ambs_pkg::SIZE_W-1:0];
      ambs_pkg::REG_FRAME_HEIGHT:   cfg_height = value[ambs_pkg::SIZE_W-1:0];
      ambs_pkg::REG_DIFF_THRESHOLD: cfg_threshold = value[ambs_pkg::THRESH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(int w, int h, int thr);
    wait_for_results();
    write_register(ambs_pkg::REG_FRAME_WIDTH, ambs_pkg::CFG_DATA_W'(w));
    write_register(ambs_pkg::REG_FRAME_HEIGHT, ambs_pkg::CFG_DATA_W'(h));
    write_register(ambs_pkg::REG_DIFF_THRESHOLD, ambs_pkg::CFG_DATA_W'(thr));
  endtask

  // The first frame covers a 16x16 corner and the start of the top row and of the left
  // column; later pixels that would leave these positions restart the frame. Only the
  // last pass ends the frame.
  task automatic test_model_load();
    int i;
    configure(16, 1024, 2500);
    for (i = 0; i < 256; i++) begin
      send_pixel(ambs_pkg::PIX_FIELD_W'($urandom_range(0, 65535)), i == 0);
    end
    no_idle = 1'b1;
    configure(64, 1024, 0);
    for (i = 0; i < 64; i++) begin
      send_pixel(ambs_pkg::PIX_FIELD_W'($urandom_range(0, 65535)), i == 0);
    end
    no_idle = 1'b0;
    configure(0, 64, 65535);
    for (i = 0; i < 64; i++) begin
      send_pixel(ambs_pkg::PIX_FIELD_W'($urandom_range(0, 65535)), i == 0);
    end
  endtask

  task automatic test_directed_cases();
    configure(4, 2, 0);
    send_pixel(near_pixel(1'b1, 0), 1'b1);
    send_pixel(near_pixel(1'b0, 1), 1'b0);
    send_pixel(near_pixel(1'b0, -1), 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(near_pixel(1'b0, 0), 1'b0);
    send_pixel(near_pixel(1'b0, 2), 1'b0);
    send_pixel(near_pixel(1'b0, 5), 1'b0);
    // No frame start here: the counters wrap on their own after the last pixel.
    send_pixel(near_pixel(1'b0, 0), 1'b0);
    send_pixel(near_pixel(1'b0, 0), 1'b0);
    configure(4, 2, 65535);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    configure(4, 2, 100);
    send_pixel(near_pixel(1'b0, 100), 1'b0);
    send_pixel(near_pixel(1'b0, 101), 1'b0);
    send_pixel(near_pixel(1'b0, -101), 1'b0);
    // Shrinking the width leaves the column past the new end of the row.
    configure(2, 2, 100);
    send_pixel(near_pixel(1'b0, 0), 1'b0);
    configure(1, 0, 100);
    send_pixel(near_pixel(1'b0, 0), 1'b0);
    send_pixel(near_pixel(1'b0, 0), 1'b0);
  endtask

  function automatic int pick_long_size();
    case ($urandom_range(0, 2))
      0:       return 1024;
      1:       return 2047;
      default: return $urandom_range(17, 1100);
    endcase
  endfunction

  function automatic int pick_threshold();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(0, 40);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic test_random_frames();
    int sent;
    int shape;
    int w;
    int h;
    int thr;
    int n;
    int i;
    int sel;
    int d;
    logic st;
    logic [ambs_pkg::PIX_FIELD_W-1:0] pix;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      shape = $urandom_range(0, 9);
      no_idle = ($urandom_range(0, 3) == 0);
      if (shape < 7) begin
        w = $urandom_range(0, 16);
        h = $urandom_range(0, 8);
        n = clamp_size(w, MAX_COLS) * clamp_size(h, MAX_ROWS) * $urandom_range(1, 3)
            + $urandom_range(0, 3);
      end else if (shape < 8) begin
        w = pick_long_size();
        h = $urandom_range(0, 1);
        n = $urandom_range(20, 60);
      end else begin
        w = $urandom_range(0, 1);
        h = pick_long_size();
        n = $urandom_range(20, 60);
      end
      thr = pick_threshold();
      configure(w, h, thr);
      for (i = 0; i < n; i++) begin
        if (i == 0) st = ($urandom_range(0, 3) != 0);
        else if (col_pos == 0 && row_pos == 0) st = ($urandom_range(0, 1) == 1);
        else st = ($urandom_range(0, 29) == 0);
        st = safe_start(st);
        sel = $urandom_range(0, 9);
        d = thr + $urandom_range(0, 4) - 2;
        if ($urandom_range(0, 1) == 0) d = -d;
        if (sel < 5) pix = near_pixel(st, d);
        else if (sel < 8) pix = ambs_pkg::PIX_FIELD_W'($urandom_range(0, 65535));
        else if (sel == 8) pix = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else pix = near_pixel(st, $urandom_range(0, 2) - 1);
        send_pixel(pix, st);
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (result_seen) begin
        result_seen = 1'b0;
        sink_hold = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      result_seen = 1'b1;
      if (pending_results.size() == 0) begin
        $error("result with no pixel pending: background_value %0d", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.foreground) begin
          $error("foreground: expected %0d, got %0d", want.foreground, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata !== want.background) begin
          $error("background_value: expected %0d, got %0d", want.background, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.frame_last) begin
          $error("frame_last: expected %0d, got %0d", want.frame_last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_model_load();
    test_directed_cases();
    test_random_frames();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
